>>> rtl/i2cdw_pkg.sv
// Package: phase codes, sequencer state and per-tick result types for the I2C DAC write master.
`timescale 1ns / 1ps

package i2cdw_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_HOLD = 4'd1,
        PH_START_SDA  = 4'd2,
        PH_START_SCL  = 4'd3,
        PH_BIT_DATA   = 4'd4,
        PH_BIT_HIGH   = 4'd5,
        PH_BIT_LOW    = 4'd6,
        PH_ACK_REL    = 4'd7,
        PH_ACK_WAIT   = 4'd8,
        PH_ACK_LOW    = 4'd9,
        PH_STOP_SDA   = 4'd10,
        PH_STOP_SCL   = 4'd11,
        PH_STOP_HOLD  = 4'd12,
        PH_STOP_REL   = 4'd13,
        PH_POST       = 4'd14
    } phase_t;

    localparam int CODE_W = 12;
    localparam int WAIT_W = 16;

    localparam logic [7:0]        DAC_ADDR_RESET   = 8'hC0;
    localparam logic [WAIT_W-1:0] POST_TICKS_RESET = 16'd10;

    // configuration register indexes
    localparam logic CFG_DAC_ADDR   = 1'b0;
    localparam logic CFG_POST_TICKS = 1'b1;

    typedef struct packed {
        phase_t              phase;
        logic [2:0]          bit_count;
        logic [1:0]          byte_count;
        logic [7:0]          shift_byte;
        logic [CODE_W-1:0]   held_code;
        logic                held_mode;
        logic [WAIT_W-1:0]   wait_count;
        logic                scl;
        logic                sda;
    } seq_state_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic done_res;
    } tick_result_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        phase:      PH_IDLE,
        bit_count:  3'd0,
        byte_count: 2'd0,
        shift_byte: 8'd0,
        held_code:  '0,
        held_mode:  1'b0,
        wait_count: '0,
        scl:        1'b1,
        sda:        1'b1
    };

endpackage

>>> rtl/i2cdw_step.sv
// One-tick next-state and pin logic of the I2C write sequencer.
`timescale 1ns / 1ps

module i2cdw_step #(
    parameter int EDGE_HOLD_TICKS = 10
) (
    input  i2cdw_pkg::seq_state_t             cur,
    input  logic                              go,
    input  logic                              func,
    input  logic [i2cdw_pkg::CODE_W-1:0]      dac_code,
    input  logic [7:0]                        probe_addr,
    input  logic                              sda_in,
    input  logic [7:0]                        dac_addr,
    input  logic [i2cdw_pkg::WAIT_W-1:0]      post_ticks,
    output i2cdw_pkg::seq_state_t             nxt,
    output i2cdw_pkg::tick_result_t           res
);
    import i2cdw_pkg::*;

    localparam logic [WAIT_W-1:0] HOLD_TICKS = WAIT_W'(EDGE_HOLD_TICKS);

    logic [WAIT_W-1:0] wait_inc;
    logic [1:0]        byte_inc;
    logic              busy;
    logic              done;

    assign wait_inc = cur.wait_count + 1'b1;
    assign byte_inc = cur.byte_count + 1'b1;

    always_comb
    begin
        nxt  = cur;
        busy = 1'b1;
        done = 1'b0;
        case (cur.phase)
            PH_START_HOLD:
            begin
                nxt.wait_count = wait_inc;
                if (wait_inc >= HOLD_TICKS)
                begin
                    nxt.phase = PH_START_SDA;
                end
            end
            PH_START_SDA:
            begin
                nxt.sda   = 1'b0;
                nxt.phase = PH_START_SCL;
            end
            PH_START_SCL:
            begin
                nxt.scl   = 1'b0;
                nxt.phase = PH_BIT_DATA;
            end
            PH_BIT_DATA:
            begin
                nxt.sda   = cur.shift_byte[7];
                nxt.phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                nxt.scl        = 1'b1;
                nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                nxt.bit_count  = cur.bit_count + 1'b1;
                nxt.phase      = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                nxt.scl   = 1'b0;
                nxt.phase = (cur.bit_count == 3'd0) ? PH_ACK_REL : PH_BIT_DATA;
            end
            PH_ACK_REL:
            begin
                nxt.sda   = 1'b1;
                nxt.phase = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                nxt.scl = 1'b1;
                if (!sda_in)
                begin
                    nxt.phase = PH_ACK_LOW;
                end
            end
            PH_ACK_LOW:
            begin
                nxt.scl        = 1'b0;
                nxt.byte_count = byte_inc;
                if (cur.held_mode || byte_inc == 2'd3)
                begin
                    nxt.phase = PH_STOP_SDA;
                end
                else
                begin
                    // high byte carries code bits 11..8 in its low nibble
                    if (byte_inc == 2'd1)
                    begin
                        nxt.shift_byte = {4'd0, cur.held_code[11:8]};
                    end
                    else
                    begin
                        nxt.shift_byte = cur.held_code[7:0];
                    end
                    nxt.phase = PH_BIT_DATA;
                end
            end
            PH_STOP_SDA:
            begin
                nxt.sda   = 1'b0;
                nxt.phase = PH_STOP_SCL;
            end
            PH_STOP_SCL:
            begin
                nxt.scl        = 1'b1;
                nxt.wait_count = '0;
                nxt.phase      = PH_STOP_HOLD;
            end
            PH_STOP_HOLD:
            begin
                nxt.wait_count = wait_inc;
                if (wait_inc >= HOLD_TICKS)
                begin
                    nxt.phase = PH_STOP_REL;
                end
            end
            PH_STOP_REL:
            begin
                nxt.sda        = 1'b1;
                nxt.wait_count = '0;
                if (!cur.held_mode && post_ticks != '0)
                begin
                    nxt.phase = PH_POST;
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
            end
            PH_POST:
            begin
                nxt.wait_count = wait_inc;
                if (wait_inc >= post_ticks)
                begin
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
                nxt.scl   = 1'b1;
                nxt.sda   = 1'b1;
                if (go)
                begin
                    nxt.held_mode  = func;
                    nxt.held_code  = dac_code;
                    nxt.shift_byte = func ? probe_addr : dac_addr;
                    nxt.bit_count  = 3'd0;
                    nxt.byte_count = 2'd0;
                    nxt.wait_count = '0;
                    nxt.phase      = PH_START_HOLD;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        res.scl_level = nxt.scl;
        res.sda_level = nxt.sda;
        res.busy_res  = busy;
        res.done_res  = done;
    end

endmodule

>>> rtl/i2c_dac_write_master.sv
// Top level of the bit-level I2C DAC write master.
`timescale 1ns / 1ps

// Each accepted input beat is one bus tick and yields exactly one output beat holding the
// SCL/SDA drive levels after that tick plus busy and done flags. The tick is evaluated
// combinationally between the sequencer state register and the output register, so one
// beat is taken every cycle; input stalls only while a finished output beat is held by a
// stalled consumer. A DAC write is start, address byte, high byte, low byte (each with an
// ack wait), stop, then post_ticks_reg idle ticks; a probe sends one byte and a stop.
// An ack wait holds until sda_in reads low, with no timeout. Configuration writes are
// taken at any time but must only be issued while the block is idle.

module i2c_dac_write_master #(
    parameter int EDGE_HOLD_TICKS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [i2cdw_pkg::WAIT_W-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               go,
    input  logic                               func,
    input  logic [i2cdw_pkg::CODE_W-1:0]       dac_code,
    input  logic [7:0]                         probe_addr,
    input  logic                               sda_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               scl_level,
    output logic                               sda_level,
    output logic                               busy_res,
    output logic                               done_res
);
    import i2cdw_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    tick_result_t      res_reg;
    tick_result_t      res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        dac_addr_reg;
    logic [WAIT_W-1:0] post_ticks_reg;
    logic              in_fire;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    i2cdw_step #(
        .EDGE_HOLD_TICKS(EDGE_HOLD_TICKS)
    ) u_step (
        .cur        (state_reg),
        .go         (go),
        .func       (func),
        .dac_code   (dac_code),
        .probe_addr (probe_addr),
        .sda_in     (sda_in),
        .dac_addr   (dac_addr_reg),
        .post_ticks (post_ticks_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_addr_reg   <= DAC_ADDR_RESET;
            post_ticks_reg <= POST_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DAC_ADDR:   dac_addr_reg   <= cfg_data[7:0];
                CFG_POST_TICKS: post_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = res_reg.scl_level;
    assign sda_level = res_reg.sda_level;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;

endmodule

>>> rtl/i2cdw_checker.sv
// Port-level checker for the I2C DAC write master, bound to the top level.
`timescale 1ns / 1ps

module i2cdw_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic scl_level,
    input logic sda_level,
    input logic busy_res,
    input logic done_res
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
            && $stable(busy_res) && $stable(done_res))
        else $error("output beat changed while stalled");

    // input only backs up behind a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done without busy");

    // idle bus has both lines released
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> scl_level && sda_level)
        else $error("line driven low while idle");

endmodule

bind i2c_dac_write_master i2cdw_checker u_i2cdw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .busy_res  (busy_res),
    .done_res  (done_res)
);

>>> bench/i2c_dac_write_master_checker.sv
// Tick predictor and output beat checker for the I2C DAC write master.
`timescale 1ns / 1ps

module i2c_dac_write_master_checker #(
    parameter int EDGE_HOLD_TICKS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [i2cdw_pkg::WAIT_W-1:0]      cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              go,
    input  logic                              func,
    input  logic [i2cdw_pkg::CODE_W-1:0]      dac_code,
    input  logic [7:0]                        probe_addr,
    input  logic                              sda_in,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              scl_level,
    input  logic                              sda_level,
    input  logic                              busy_res,
    input  logic                              done_res,
    output int                                fail_count,
    output int                                pending_ticks,
    output logic                              seq_idle
);
    import i2cdw_pkg::*;

    phase_t             ph;
    logic [2:0]         bit_cnt;
    logic [1:0]         byte_cnt;
    logic [7:0]         shift_q;
    logic [CODE_W-1:0]  code_q;
    logic               mode_q;
    logic [WAIT_W-1:0]  wait_cnt;
    logic               scl_q;
    logic               sda_q;
    logic [7:0]         dac_addr;
    logic [WAIT_W-1:0]  post_ticks;

    tick_result_t       expected_levels[$];
    tick_result_t       got;
    tick_result_t       want;
    int                 bad_beats;

    assign fail_count = bad_beats;

    function automatic tick_result_t advance_bus_tick(input logic go_i, input logic func_i,
                                                      input logic [CODE_W-1:0] code_i,
                                                      input logic [7:0] probe_i,
                                                      input logic sda_i);
        tick_result_t r;
        logic         busy;
        logic         done;
        busy = 1'b1;
        done = 1'b0;
        case (ph)
            PH_START_HOLD:
            begin
                wait_cnt = wait_cnt + 1'b1;
                if (wait_cnt >= WAIT_W'(EDGE_HOLD_TICKS))
                    ph = PH_START_SDA;
            end
            PH_START_SDA:
            begin
                sda_q = 1'b0;
                ph = PH_START_SCL;
            end
            PH_START_SCL:
            begin
                scl_q = 1'b0;
                ph = PH_BIT_DATA;
            end
            PH_BIT_DATA:
            begin
                sda_q = shift_q[7];
                ph = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                scl_q = 1'b1;
                shift_q = {shift_q[6:0], 1'b0};
                bit_cnt = bit_cnt + 1'b1;
                ph = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                scl_q = 1'b0;
                if (bit_cnt == 3'd0)
                    ph = PH_ACK_REL;
                else
                    ph = PH_BIT_DATA;
            end
            PH_ACK_REL:
            begin
                sda_q = 1'b1;
                ph = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                scl_q = 1'b1;
                if (!sda_i)
                    ph = PH_ACK_LOW;
            end
            PH_ACK_LOW:
            begin
                scl_q = 1'b0;
                byte_cnt = byte_cnt + 1'b1;
                if (mode_q || byte_cnt == 2'd3)
                    ph = PH_STOP_SDA;
                else
                begin
                    if (byte_cnt == 2'd1)
                        shift_q = {4'h0, code_q[11:8]};
                    else
                        shift_q = code_q[7:0];
                    ph = PH_BIT_DATA;
                end
            end
            PH_STOP_SDA:
            begin
                sda_q = 1'b0;
                ph = PH_STOP_SCL;
            end
            PH_STOP_SCL:
            begin
                scl_q = 1'b1;
                wait_cnt = '0;
                ph = PH_STOP_HOLD;
            end
            PH_STOP_HOLD:
            begin
                wait_cnt = wait_cnt + 1'b1;
                if (wait_cnt >= WAIT_W'(EDGE_HOLD_TICKS))
                    ph = PH_STOP_REL;
            end
            PH_STOP_REL:
            begin
                sda_q = 1'b1;
                wait_cnt = '0;
                if (!mode_q && post_ticks != '0)
                    ph = PH_POST;
                else
                begin
                    ph = PH_IDLE;
                    done = 1'b1;
                end
            end
            PH_POST:
            begin
                wait_cnt = wait_cnt + 1'b1;
                if (wait_cnt >= post_ticks)
                begin
                    ph = PH_IDLE;
                    done = 1'b1;
                end
            end
            default:
            begin
                ph = PH_IDLE;
                scl_q = 1'b1;
                sda_q = 1'b1;
                if (go_i)
                begin
                    mode_q = func_i;
                    code_q = code_i;
                    shift_q = func_i ? probe_i : dac_addr;
                    bit_cnt = '0;
                    byte_cnt = '0;
                    wait_cnt = '0;
                    ph = PH_START_HOLD;
                end
                else
                    busy = 1'b0;
            end
        endcase
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res = busy;
        r.done_res = done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph = PH_IDLE;
            bit_cnt = '0;
            byte_cnt = '0;
            shift_q = '0;
            code_q = '0;
            mode_q = 1'b0;
            wait_cnt = '0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            dac_addr = DAC_ADDR_RESET;
            post_ticks = POST_TICKS_RESET;
            bad_beats = 0;
            expected_levels.delete();
            pending_ticks <= 0;
            seq_idle <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DAC_ADDR)
                    dac_addr = cfg_data[7:0];
                else
                    post_ticks = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = '{scl_level, sda_level, busy_res, done_res};
                if (expected_levels.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("unexpected output beat: scl=%b sda=%b busy=%b done=%b",
                                 got.scl_level, got.sda_level, got.busy_res, got.done_res);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got !== want)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("tick mismatch at %0t: scl/sda/busy/done exp %b%b%b%b got %b%b%b%b",
                                     $time, want.scl_level, want.sda_level, want.busy_res,
                                     want.done_res, got.scl_level, got.sda_level,
                                     got.busy_res, got.done_res);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_levels.push_back(advance_bus_tick(go, func, dac_code, probe_addr,
                                                           sda_in));
            pending_ticks <= expected_levels.size();
            seq_idle <= (ph == PH_IDLE);
        end
    end

endmodule

>>> bench/i2c_dac_write_master_test.sv
// Testbench top: clock, reset, tick stimulus, bus stalls and final verdict.
`timescale 1ns / 1ps

module i2c_dac_write_master_test;
    import i2cdw_pkg::*;

    localparam int EDGE_HOLD   = 10;
    localparam int STALL_LIMIT = 4000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_DAC_ADDR;
    logic [WAIT_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               go = 1'b0;
    logic               func = 1'b0;
    logic [CODE_W-1:0]  dac_code = '0;
    logic [7:0]         probe_addr = '0;
    logic               sda_in = 1'b1;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               scl_level;
    logic               sda_level;
    logic               busy_res;
    logic               done_res;

    int                 fail_count;
    int                 pending_ticks;
    logic               seq_idle;

    int                 burst_left = 0;
    int                 idle_cycles = 0;
    int                 stall_run = 0;
    stall_style_t       stall_mode = STALL_NONE;
    logic [2:0]         stall_phase = '0;

    i2c_dac_write_master #(.EDGE_HOLD_TICKS(EDGE_HOLD)) dut (.*);

    i2c_dac_write_master_checker #(.EDGE_HOLD_TICKS(EDGE_HOLD)) u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= stall_style_t'($urandom_range(0, 3));
            stall_run <= $urandom_range(16, 256);
        end
        else
            stall_run <= stall_run - 1;
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 1) == 0);
            STALL_PERIODIC: out_stall <= (stall_phase < 3'd3);
            default:        out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("i2c_dac_write_master_test NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_tick(input logic g, input logic f, input logic [CODE_W-1:0] c,
                             input logic [7:0] p, input logic s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        go <= g;
        func <= f;
        dac_code <= c;
        probe_addr <= p;
        sda_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drive idle ticks until the sequencer is back in idle, then drain all beats
    task automatic quiesce();
        do
            send_tick(1'b0, 1'b0, '0, '0, 1'b0);
        while (!seq_idle);
        in_valid <= 1'b0;
        while (pending_ticks != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] addr, input logic [WAIT_W-1:0] post);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DAC_ADDR;
        cfg_data <= {8'h00, addr};
        @(posedge clk);
        cfg_index <= CFG_POST_TICKS;
        cfg_data <= post;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one transaction; go is repeated with other fields early on and must be ignored, then
    // sda_in stays high (no ack) for the first hold ticks of the wait loop
    task automatic directed_txn(input logic f, input logic [CODE_W-1:0] c,
                                input logic [7:0] p, input int hold);
        int k;
        send_tick(1'b1, f, c, p, 1'b1);
        repeat (5) send_tick(1'b1, ~f, ~c, ~p, 1'b0);
        k = 0;
        do
        begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)), k < hold);
            k++;
        end
        while (!seq_idle);
    endtask

    task automatic run_phase(input logic [7:0] addr, input logic [WAIT_W-1:0] post,
                             input int ticks, input int ack_div);
        configure(addr, post);
        repeat (ticks)
            send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                      CODE_W'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, ack_div) != 0);
        quiesce();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_txn(1'b0, 12'h000, 8'h00, 0);
        directed_txn(1'b1, 12'h000, 8'hFF, 0);
        directed_txn(1'b0, 12'h5A3, 8'h3C, 40);
        quiesce();

        // zero post-delay
        configure(8'h00, 16'd0);
        directed_txn(1'b0, 12'hA5C, 8'h81, 0);
        directed_txn(1'b1, 12'h3C5, 8'h7E, 40);
        quiesce();

        run_phase(8'hFF, 16'd1, 48, 0);
        run_phase(8'h00, 16'd0, 48, 2);
        repeat (2)
            run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)), 48,
                      $urandom_range(0, 6));

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_ticks == 0)
            $display("i2c_dac_write_master_test OK");
        else
            $display("i2c_dac_write_master_test NOT OK");
        $finish;
    end

endmodule
